// File: rtl/core/erv3_pkg.sv
package erv3_pkg;

  // Width of a sine or cosine magnitude in Q2.30 (1.0 is 2^30).
  localparam int unsigned TrigMagBits = 31;

  // One point zero in Q2.30.
  localparam logic [30:0] OneQ30 = 31'h4000_0000;

  // Fractional part of pi/2 in Q32; the integer part is one.
  localparam logic [31:0] PiHalfFrac = 32'h921F_B544;

  // Number of series steps: four sine terms, then five cosine terms.
  localparam logic [3:0] LastStep = 4'd8;
  localparam logic [3:0] LastSinStep = 4'd3;

  // Sine and cosine of one angle, in sign and magnitude form.
  typedef struct packed {
    logic        s_neg;
    logic [30:0] s_mag;
    logic        c_neg;
    logic [30:0] c_mag;
  } trig_t;

  // Sequencer states of the trig engine.
  typedef enum logic [3:0] {
    TS_IDLE,
    TS_TMUL,
    TS_TSET,
    TS_TSQR,
    TS_T2SET,
    TS_TERM,
    TS_QUOT,
    TS_RECIP,
    TS_ACC,
    TS_DONE
  } trig_state_e;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    REG_ANGLE_X = 2'd0,
    REG_ANGLE_Y = 2'd1,
    REG_ANGLE_Z = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_e;

  // Rounded-up reciprocal of the integer factor that divides the series term
  // of each step. With the matching shift below, the quotient is exact for
  // every numerator below 2^30.
  function automatic logic [31:0] step_recip(input logic [3:0] step);
    logic [31:0] m;
    case (step)
      4'd0:    m = 32'd1431655766;  // 1/6
      4'd1:    m = 32'd1717986919;  // 1/20
      4'd2:    m = 32'd1636178018;  // 1/42
      4'd3:    m = 32'd1908874354;  // 1/72
      4'd4:    m = 32'd1073741824;  // 1/2
      4'd5:    m = 32'd1431655766;  // 1/12
      4'd6:    m = 32'd1145324613;  // 1/30
      4'd7:    m = 32'd1227133514;  // 1/56
      4'd8:    m = 32'd1527099484;  // 1/90
      default: m = 32'd0;
    endcase
    return m;
  endfunction

  // Right shift that goes with each reciprocal.
  function automatic logic [5:0] step_shift(input logic [3:0] step);
    logic [5:0] s;
    case (step)
      4'd0:    s = 6'd33;
      4'd1:    s = 6'd35;
      4'd2:    s = 6'd36;
      4'd3:    s = 6'd37;
      4'd4:    s = 6'd31;
      4'd5:    s = 6'd34;
      4'd6:    s = 6'd35;
      4'd7:    s = 6'd36;
      4'd8:    s = 6'd37;
      default: s = 6'd31;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/core/erv3_trig_engine.sv
module erv3_trig_engine import erv3_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] angle_i,
  output logic        busy_o,
  output logic        done_o,
  output trig_t       trig_o
);

  localparam logic [31:0] AngleMask =
      (ANGLE_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ANGLE_BITS) - 64'd1);
  localparam int PhaseShift = 32 - ANGLE_BITS;

  trig_state_e state_q, state_d;
  logic [29:0] r_q, r_d;
  logic [1:0]  quad_q, quad_d;
  logic        swap_q, swap_d;
  logic [30:0] t_q, t_d;
  logic [30:0] t2_q, t2_d;
  logic [30:0] term_q, term_d;
  logic [30:0] num_q, num_d;
  logic [3:0]  k_q, k_d;
  logic signed [32:0] ss_q, ss_d, cc_q, cc_d;
  logic [63:0] prod_q;
  logic [31:0] mul_a, mul_b;

  logic [31:0] phase;
  logic [29:0] r_raw;
  logic [30:0] quot;
  logic [63:0] t_round;
  logic [63:0] q30_round;
  logic [30:0] ss_clip, cc_clip, s_m, c_m;

  // Phase split into quadrant and mirrored position within it.
  assign phase   = (32'(angle_i) & AngleMask) << PhaseShift;
  assign r_raw   = phase[29:0];
  assign quot    = 31'(prod_q >> step_shift(k_q));
  assign t_round   = prod_q + 64'h8000_0000;
  assign q30_round = prod_q + 64'h2000_0000;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      TS_IDLE:  if (start_i) state_d = TS_TMUL;
      TS_TMUL:  state_d = TS_TSET;
      TS_TSET:  state_d = TS_TSQR;
      TS_TSQR:  state_d = TS_T2SET;
      TS_T2SET: state_d = TS_TERM;
      TS_TERM:  state_d = TS_QUOT;
      TS_QUOT:  state_d = TS_RECIP;
      TS_RECIP: state_d = TS_ACC;
      TS_ACC:   state_d = (k_q == LastStep) ? TS_DONE : TS_TERM;
      TS_DONE:  state_d = TS_IDLE;
      default:  state_d = TS_IDLE;
    endcase
  end

  // Datapath: one shared multiplier, used for the series products and for
  // the reciprocal multiplication that divides each term by its factor.
  always_comb begin
    r_d = r_q; quad_d = quad_q; swap_d = swap_q; t_d = t_q; t2_d = t2_q;
    term_d = term_q; num_d = num_q; k_d = k_q;
    ss_d = ss_q; cc_d = cc_q;
    mul_a = 32'(term_q);
    mul_b = 32'(t2_q);
    case (state_q)
      TS_IDLE: begin
        quad_d = phase[31:30];
        swap_d = r_raw > 30'h2000_0000;
        r_d    = swap_d ? 30'(31'h4000_0000 - {1'b0, r_raw}) : r_raw;
      end
      TS_TMUL: begin
        mul_a = 32'(r_q);
        mul_b = PiHalfFrac;
      end
      TS_TSET: t_d = 31'(r_q) + 31'(t_round[63:32]);
      TS_TSQR: begin
        mul_a = 32'(t_q);
        mul_b = 32'(t_q);
      end
      TS_T2SET: begin
        t2_d   = 31'(q30_round[63:30]);
        term_d = t_q;
        ss_d   = 33'(t_q);
        cc_d   = 33'(OneQ30);
        k_d    = 4'd0;
      end
      TS_QUOT: num_d = 31'(q30_round[63:30]);
      TS_RECIP: begin
        mul_a = 32'(num_q);
        mul_b = step_recip(k_q);
      end
      TS_ACC: begin
        // Even steps subtract their term in both series.
        if (k_q <= LastSinStep) begin
          ss_d = k_q[0] ? ss_q + 33'(quot) : ss_q - 33'(quot);
        end else begin
          cc_d = k_q[0] ? cc_q + 33'(quot) : cc_q - 33'(quot);
        end
        term_d = (k_q == LastSinStep) ? OneQ30 : quot;
        k_d    = k_q + 4'd1;
      end
      default: ;
    endcase
  end

  // Quadrant fold of the clipped series results.
  always_comb begin
    ss_clip = ss_q[32] ? 31'd0 : ss_q[30:0];
    cc_clip = cc_q[32] ? 31'd0 : cc_q[30:0];
    s_m = swap_q ? cc_clip : ss_clip;
    c_m = swap_q ? ss_clip : cc_clip;
    case (quad_q)
      2'd0:    trig_o = '{s_neg: 1'b0, s_mag: s_m, c_neg: 1'b0, c_mag: c_m};
      2'd1:    trig_o = '{s_neg: 1'b0, s_mag: c_m, c_neg: 1'b1, c_mag: s_m};
      2'd2:    trig_o = '{s_neg: 1'b1, s_mag: s_m, c_neg: 1'b1, c_mag: c_m};
      default: trig_o = '{s_neg: 1'b1, s_mag: c_m, c_neg: 1'b0, c_mag: s_m};
    endcase
  end

  assign busy_o = state_q != TS_IDLE;
  assign done_o = state_q == TS_DONE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d; quad_q <= quad_d; swap_q <= swap_d; t_q <= t_d; t2_q <= t2_d;
    term_q <= term_d; num_q <= num_d; k_q <= k_d;
    ss_q <= ss_d; cc_q <= cc_d;
    prod_q <= 64'(mul_a) * 64'(mul_b);
  end

endmodule

// File: rtl/core/erv3_rotate_cell.sv
module erv3_rotate_cell import erv3_pkg::*; #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  trig_t                        trig_i,
  input  logic signed [COORD_BITS-1:0] u_i,
  input  logic signed [COORD_BITS-1:0] v_i,
  input  logic signed [COORD_BITS-1:0] w_i,
  output logic signed [COORD_BITS-1:0] a_o,
  output logic signed [COORD_BITS-1:0] b_o,
  output logic signed [COORD_BITS-1:0] w_o
);

  localparam int CB = COORD_BITS;

  // Rounded product of a coordinate and a Q2.30 magnitude, ties away from zero.
  function automatic logic signed [CB+1:0] rprod(input logic signed [CB-1:0] a,
                                                 input logic neg, input logic [30:0] m);
    logic [CB-1:0]  amag;
    logic [CB+30:0] full;
    logic [CB:0]    q;
    amag = a[CB-1] ? CB'(-a) : CB'(a);
    full = ((CB+31)'(amag) * (CB+31)'(m)) + (CB+31)'(32'h2000_0000);
    q    = full[CB+30:30];
    return (a[CB-1] ^ neg) ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  // Clamp a grown sum to the coordinate range.
  function automatic logic signed [CB-1:0] sat(input logic signed [CB+2:0] s);
    logic ovf;
    ovf = (s[CB+2:CB-1] != '0) && (s[CB+2:CB-1] != '1);
    if (ovf) return s[CB+2] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
    return s[CB-1:0];
  endfunction

  logic signed [CB+1:0] uc_q, vs_q, us_q, vc_q;
  logic signed [CB-1:0] w1_q, a_q, b_q, w2_q;

  // Stage one: four rounded products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      uc_q <= rprod(u_i, trig_i.c_neg, trig_i.c_mag);
      vs_q <= rprod(v_i, trig_i.s_neg, trig_i.s_mag);
      us_q <= rprod(u_i, trig_i.s_neg, trig_i.s_mag);
      vc_q <= rprod(v_i, trig_i.c_neg, trig_i.c_mag);
      w1_q <= w_i;
    end
  end

  // Stage two: sums and saturation.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q  <= sat((CB+3)'(uc_q) - (CB+3)'(vs_q));
      b_q  <= sat((CB+3)'(us_q) + (CB+3)'(vc_q));
      w2_q <= w1_q;
    end
  end

  assign a_o = a_q;
  assign b_o = b_q;
  assign w_o = w2_q;

endmodule

// File: rtl/core/euler_rotate_vector3_unit.sv
// Rotates a stream of signed Q7.16 points about X, then Y, then Z by three binary
// angles (65536 is a full turn) held in APB registers at byte addresses 0, 4 and 8.
// A point enters every cycle while the pipeline is not stalled and no angle is being
// evaluated, and passes through a chain of three identical rotation cells, two stages
// each; the output register is the last stage. Writing an angle starts a sine and
// cosine series evaluation in a shared sequencer with one multiplier, which also
// divides each series term by its factor through a rounded-up reciprocal; the new sine
// and cosine of an angle are put in place when its evaluation is done, and s_axis_tready
// stays low until all written angles are evaluated.
module euler_rotate_vector3_unit import erv3_pkg::*; #(
  parameter int COORD_BITS = 24,
  parameter int ANGLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata fields from bit 0: in_x, in_y, in_z, zero fill
  input  logic [((3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata fields from bit 0: out_x, out_y, out_z, zero fill
  output logic [((3*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CB = COORD_BITS;
  localparam int TdataW = ((3*COORD_BITS+7)/8)*8;
  localparam int Stages = 6;

  logic [15:0] ang_x_q, ang_y_q, ang_z_q;
  logic [2:0]  pend_q, pend_d;
  logic [1:0]  sel_q;
  logic [1:0]  pick;
  logic [15:0] pick_angle;
  logic        cfg_we;
  reg_idx_e    widx;
  logic        eng_busy, eng_done, eng_start, trig_idle;
  trig_t       eng_trig;
  trig_t       trig_x_q, trig_y_q, trig_z_q;
  logic [Stages-1:0] vld_q;
  logic        adv;
  logic signed [CB-1:0] y1, z1, x1, z2, x2, y2, x3, y3, z3;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  assign widx   = reg_idx_e'(paddr[3:2]);

  always_comb begin
    case (widx)
      REG_ANGLE_X: prdata = 32'(ang_x_q);
      REG_ANGLE_Y: prdata = 32'(ang_y_q);
      REG_ANGLE_Z: prdata = 32'(ang_z_q);
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_x_q <= 16'd0;
      ang_y_q <= 16'd0;
      ang_z_q <= 16'd0;
    end else if (cfg_we) begin
      case (widx)
        REG_ANGLE_X: ang_x_q <= pwdata[15:0];
        REG_ANGLE_Y: ang_y_q <= pwdata[15:0];
        REG_ANGLE_Z: ang_z_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Pending evaluations; the lowest pending angle goes to the engine first.
  always_comb begin
    pick = pend_q[0] ? REG_ANGLE_X : (pend_q[1] ? REG_ANGLE_Y : REG_ANGLE_Z);
    case (reg_idx_e'(pick))
      REG_ANGLE_X: pick_angle = ang_x_q;
      REG_ANGLE_Y: pick_angle = ang_y_q;
      default:     pick_angle = ang_z_q;
    endcase
    eng_start = !eng_busy && (pend_q != 3'd0);
    pend_d = pend_q;
    if (eng_start) pend_d[pick] = 1'b0;
    if (cfg_we && widx != REG_NONE) pend_d[widx] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 3'd0;
      sel_q  <= REG_ANGLE_X;
    end else begin
      pend_q <= pend_d;
      if (eng_start) sel_q <= pick;
    end
  end

  erv3_trig_engine #(.ANGLE_BITS(ANGLE_BITS)) u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (eng_start),
    .angle_i (pick_angle),
    .busy_o  (eng_busy),
    .done_o  (eng_done),
    .trig_o  (eng_trig)
  );

  // Sine and cosine per axis; reset matches angle zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_x_q <= '{s_neg: 1'b0, s_mag: 31'd0, c_neg: 1'b0, c_mag: OneQ30};
      trig_y_q <= '{s_neg: 1'b0, s_mag: 31'd0, c_neg: 1'b0, c_mag: OneQ30};
      trig_z_q <= '{s_neg: 1'b0, s_mag: 31'd0, c_neg: 1'b0, c_mag: OneQ30};
    end else if (eng_done) begin
      case (reg_idx_e'(sel_q))
        REG_ANGLE_X: trig_x_q <= eng_trig;
        REG_ANGLE_Y: trig_y_q <= eng_trig;
        default:     trig_z_q <= eng_trig;
      endcase
    end
  end

  // Pipeline advance and valid tracking.
  assign trig_idle     = !eng_busy && (pend_q == 3'd0);
  assign adv           = !vld_q[Stages-1] || m_axis_tready;
  assign s_axis_tready = adv && trig_idle;
  assign m_axis_tvalid = vld_q[Stages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Stages-2:0], s_axis_tvalid && s_axis_tready};
    end
  end

  // Rotation about X.
  erv3_rotate_cell #(.COORD_BITS(CB)) u_cell_x (
    .clk_i (clk_i), .en_i (adv), .trig_i (trig_x_q),
    .u_i (s_axis_tdata[2*CB-1:CB]), .v_i (s_axis_tdata[3*CB-1:2*CB]),
    .w_i (s_axis_tdata[CB-1:0]),
    .a_o (y1), .b_o (z1), .w_o (x1)
  );

  // Rotation about Y works on the (z, x) pair.
  erv3_rotate_cell #(.COORD_BITS(CB)) u_cell_y (
    .clk_i (clk_i), .en_i (adv), .trig_i (trig_y_q),
    .u_i (z1), .v_i (x1), .w_i (y1),
    .a_o (z2), .b_o (x2), .w_o (y2)
  );

  // Rotation about Z.
  erv3_rotate_cell #(.COORD_BITS(CB)) u_cell_z (
    .clk_i (clk_i), .en_i (adv), .trig_i (trig_z_q),
    .u_i (x2), .v_i (y2), .w_i (z2),
    .a_o (x3), .b_o (y3), .w_o (z3)
  );

  assign m_axis_tdata = TdataW'({z3, y3, x3});

  // No point is taken while any angle evaluation is open.
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
      s_axis_tvalid && s_axis_tready |-> !eng_busy && pend_q == 3'd0)
    else $error("point taken during angle evaluation");

  // An angle write blocks input in the following cycle.
  a_write_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cfg_we && widx != REG_NONE |=> !s_axis_tready)
    else $error("input open right after angle write");

  // The pipeline valid bits hold while stalled.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !adv |=> $stable(vld_q))
    else $error("pipeline moved during stall");

  // The engine only finishes while busy.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
      eng_done |-> eng_busy)
    else $error("engine done while idle");

endmodule
